FILE: sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared constants, register codes and control structs of the engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MME_MAX_DIM   = 8;
  localparam int MME_ELEM_BITS = 16;
  localparam int MME_OUT_BITS  = 35;
  localparam int MME_IN_BITS   = 16;
  localparam int MME_POS_BITS  = 3;
  localparam int MME_DIM_BITS  = 4;

  localparam logic [MME_DIM_BITS-1:0] MME_DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_INNER = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic [MME_POS_BITS-1:0] k;
  } mme_tok_t;

  typedef struct packed {
    logic                    en;
    logic [MME_POS_BITS-1:0] row;
    logic [MME_POS_BITS-1:0] col;
  } mme_bwr_t;

  function automatic logic [MME_DIM_BITS-1:0] clamp_dim(
    input logic [MME_DIM_BITS-1:0] v,
    input logic [MME_DIM_BITS-1:0] maxd
  );
    logic [MME_DIM_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = MME_DIM_BITS'(1);
    end else if (v > maxd) begin
      r = maxd;
    end
    return r;
  endfunction

endpackage

FILE: sv/mme_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one element write item.
// ----------------------------------------------------------------------------
interface mme_in_if;
  logic               valid;
  logic               ready;
  logic               which_matrix;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [15:0] element_value;
  logic               go;

  modport source (output valid, which_matrix, row_index, col_index, element_value, go,
                  input ready);
  modport sink   (input valid, which_matrix, row_index, col_index, element_value, go,
                  output ready);
endinterface

FILE: sv/mme_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one element of the product matrix.
// ----------------------------------------------------------------------------
interface mme_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [34:0] product_value;
  logic               last;

  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

FILE: sv/mme_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface mme_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/mme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: sv/mme_cell.sv
// ----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one column of B, multiplies the passing A element and accumulates.
// ----------------------------------------------------------------------------
module mme_cell #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16,
  parameter int COL       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mme_pkg::mme_bwr_t                    bwr,
  input  logic signed [ELEM_BITS-1:0]          bwr_data,
  input  mme_pkg::mme_tok_t                    tok_in,
  input  logic signed [ELEM_BITS-1:0]          a_in,
  output mme_pkg::mme_tok_t                    tok_out,
  output logic signed [ELEM_BITS-1:0]          a_out,
  output logic signed [mme_pkg::MME_OUT_BITS-1:0] res
);
  import mme_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);

  logic signed [ELEM_BITS-1:0]    bcol_r [MAX_DIM];
  mme_tok_t                       tok_r;
  logic signed [ELEM_BITS-1:0]    a_r;
  logic signed [2*ELEM_BITS-1:0]  prod_r;
  logic signed [MME_OUT_BITS-1:0] prod_ext;
  logic signed [MME_OUT_BITS-1:0] sum_nxt;
  logic signed [MME_OUT_BITS-1:0] acc_r;
  logic signed [MME_OUT_BITS-1:0] res_r;

  assign prod_ext = MME_OUT_BITS'(prod_r);
  assign sum_nxt  = tok_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (bwr.en && bwr.col == MME_POS_BITS'(COL)) begin
      bcol_r[bwr.row[IDX_W-1:0]] <= bwr_data;
    end
    a_r    <= a_in;
    prod_r <= a_in * bcol_r[tok_in.k[IDX_W-1:0]];
    if (tok_r.valid) begin
      acc_r <= sum_nxt;
      if (tok_r.last) begin
        res_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  assign tok_out = tok_r;
  assign a_out   = a_r;
  assign res     = res_r;

endmodule

FILE: sv/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Computes C = A x B with A held in a RAM and B spread over a row of cells.
// ----------------------------------------------------------------------------
// Each item on in_ch writes one element of A or B; B elements go into the
// cell that owns that column. Items are taken one per cycle while the engine
// is idle. An item with go set starts a run after it is stored: for each row
// of A the sequencer reads the inner elements from the RAM, one per cycle,
// and passes them down the chain of cells, one cell per column, each cell
// multiplying and accumulating. After the chain has drained, the row's
// results leave on out_ch one per cycle while the receiver is ready, in
// row-major order, last set on the final item. in_ch is not ready during
// a run. The sizes are written on cfg_ch, which is always ready. A stalled
// receiver holds the output register and the sequencer waits. Reset sets
// all sizes to eight and empties the pipeline; the stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
  parameter int MAX_DIM   = mme_pkg::MME_MAX_DIM,
  parameter int ELEM_BITS = mme_pkg::MME_ELEM_BITS
) (
  input logic        clk,
  input logic        rst_n,
  mme_in_if.sink     in_ch,
  mme_out_if.source  out_ch,
  mme_cfg_if.sink    cfg_ch
);
  import mme_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int WAIT_W = $clog2(MAX_DIM + 2);
  localparam logic [MME_DIM_BITS-1:0] MAX_D = MME_DIM_BITS'(MAX_DIM);

  typedef enum logic [1:0] {S_IDLE, S_FEED, S_WAIT, S_EMIT} state_t;

  state_t                         state_r;
  logic [MME_DIM_BITS-1:0]        rows_r, cols_r, inner_r;
  logic [MME_DIM_BITS-1:0]        m_dim, n_dim, k_dim;
  logic [IDX_W-1:0]               i_r, k_r, j_r;
  logic [WAIT_W-1:0]              wait_r;
  mme_tok_t                       tok_r;
  logic                           out_valid_r, out_last_r;
  logic [MME_POS_BITS-1:0]        out_row_r, out_col_r;
  logic signed [MME_OUT_BITS-1:0] out_val_r;

  logic                           in_acc, in_range;
  logic                           out_fire;
  logic signed [ELEM_BITS-1:0]    elem;
  logic [ADDR_W-1:0]              waddr, raddr;
  logic signed [ELEM_BITS-1:0]    a_rd;
  mme_bwr_t                       bwr;
  logic                           k_end, j_end, i_end;

  mme_tok_t                       tok_c [MAX_DIM+1];
  logic signed [ELEM_BITS-1:0]    a_c   [MAX_DIM+1];
  logic signed [MME_OUT_BITS-1:0] res_c [MAX_DIM];

  assign m_dim = clamp_dim(rows_r, MAX_D);
  assign n_dim = clamp_dim(cols_r, MAX_D);
  assign k_dim = clamp_dim(inner_r, MAX_D);

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_range     = ({1'b0, in_ch.row_index} < MAX_D) && ({1'b0, in_ch.col_index} < MAX_D);
  assign elem         = ELEM_BITS'(in_ch.element_value);
  assign waddr = ADDR_W'(int'(in_ch.row_index) * MAX_DIM + int'(in_ch.col_index));
  assign raddr = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign out_fire = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  assign bwr.en  = in_acc && in_ch.which_matrix && in_range;
  assign bwr.row = in_ch.row_index;
  assign bwr.col = in_ch.col_index;

  assign k_end = (MME_DIM_BITS'(k_r) + MME_DIM_BITS'(1)) == k_dim;
  assign j_end = (MME_DIM_BITS'(j_r) + MME_DIM_BITS'(1)) == n_dim;
  assign i_end = (MME_DIM_BITS'(i_r) + MME_DIM_BITS'(1)) == m_dim;

  mme_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(MAX_DIM * MAX_DIM)
  ) u_store_a (
    .clk  (clk),
    .we   (in_acc && !in_ch.which_matrix && in_range),
    .waddr(waddr),
    .wdata(elem),
    .raddr(raddr),
    .rdata(a_rd)
  );

  assign tok_c[0] = tok_r;
  assign a_c[0]   = a_rd;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    mme_cell #(
      .MAX_DIM  (MAX_DIM),
      .ELEM_BITS(ELEM_BITS),
      .COL      (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bwr     (bwr),
      .bwr_data(elem),
      .tok_in  (tok_c[g]),
      .a_in    (a_c[g]),
      .tok_out (tok_c[g+1]),
      .a_out   (a_c[g+1]),
      .res     (res_c[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= MME_DIM_RESET;
      cols_r  <= MME_DIM_RESET;
      inner_r <= MME_DIM_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_ROWS:  rows_r  <= cfg_ch.data;
        CFG_COLS:  cols_r  <= cfg_ch.data;
        CFG_INNER: inner_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
      wait_r      <= '0;
      tok_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tok_r <= (state_r == S_FEED) ?
               mme_tok_t'{valid: 1'b1, first: (k_r == '0), last: k_end,
                          k: MME_POS_BITS'(k_r)} :
               mme_tok_t'('0);
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.go) begin
            state_r <= S_FEED;
            i_r     <= '0;
            k_r     <= '0;
          end
        end
        S_FEED: begin
          if (k_end) begin
            k_r     <= '0;
            wait_r  <= WAIT_W'(MAX_DIM + 1);
            state_r <= S_WAIT;
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (wait_r == '0) begin
            j_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            wait_r <= wait_r - WAIT_W'(1);
          end
        end
        S_EMIT: begin
          if (out_fire) begin
            out_row_r   <= MME_POS_BITS'(i_r);
            out_col_r   <= MME_POS_BITS'(j_r);
            out_val_r   <= res_c[j_r];
            out_last_r  <= i_end && j_end;
            if (j_end) begin
              if (i_end) begin
                state_r <= S_IDLE;
              end else begin
                i_r     <= i_r + IDX_W'(1);
                state_r <= S_FEED;
              end
            end else begin
              j_r <= j_r + IDX_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.last          = out_last_r;

`ifndef ASSERT_OFF
  a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.go |=> state_r == S_FEED)
    else $error("go item did not start a run");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FEED |-> MME_DIM_BITS'(k_r) < k_dim)
    else $error("inner index beyond inner size");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |->
      (MME_DIM_BITS'(out_row_r) + MME_DIM_BITS'(1) == m_dim) &&
      (MME_DIM_BITS'(out_col_r) + MME_DIM_BITS'(1) == n_dim))
    else $error("last item not at final position");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads both matrices item by item, starts products with go and checks each
// result element against a predictor, over several matrix sizes and with
// random idling on the input and result channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mme_pkg::*;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [34:0] value;
    logic               last;
  } c_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();
  mme_cfg_if cfg_ch ();

  matrix_multiply_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  logic signed [15:0] mat_a [0:7][0:7];
  logic signed [15:0] mat_b [0:7][0:7];
  bit                 a_written [0:7][0:7];
  bit                 b_written [0:7][0:7];
  logic [3:0]         n_rows = 4'd8;
  logic [3:0]         n_cols = 4'd8;
  logic [3:0]         n_inner = 4'd8;
  c_elem_t            pending_c [$];
  int                 n_errors = 0;
  int                 n_results = 0;
  int                 n_runs = 0;
  int                 n_items = 0;
  int                 idle_cycles = 0;
  bit                 hold_off = 1'b0;
  bit                 bursty = 1'b1;

  localparam int WATCHDOG_LIMIT = 20000;

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.which_matrix <= 1'b0;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.element_value <= '0;
    in_ch.go <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    out_ch.ready <= 1'b0;
  end

  function automatic int clip_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  function automatic int gap_len();
    if (!bursty) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic predict_product();
    int m, n, kk;
    logic signed [34:0] acc;
    m = clip_dim(n_rows);
    n = clip_dim(n_cols);
    kk = clip_dim(n_inner);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < kk; k++) begin
          acc += 35'(mat_a[i][k] * mat_b[k][j]);
        end
        pending_c.push_back('{row: 3'(i), col: 3'(j), value: acc,
                              last: (i == m - 1) && (j == n - 1)});
      end
    end
    n_runs++;
  endtask

  task automatic send_element(bit which, int r, int c, logic signed [15:0] v, bit go);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.which_matrix <= which;
    in_ch.row_index <= 3'(r);
    in_ch.col_index <= 3'(c);
    in_ch.element_value <= v;
    in_ch.go <= go;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (which) begin
      mat_b[r][c] = v;
      b_written[r][c] = 1'b1;
    end else begin
      mat_a[r][c] = v;
      a_written[r][c] = 1'b1;
    end
    if (go) predict_product();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_c.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(cfg_idx_t idx, logic [3:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ROWS:  n_rows = v;
      CFG_COLS:  n_cols = v;
      default:   n_inner = v;
    endcase
  endtask

  task automatic set_sizes(logic [3:0] r, logic [3:0] c, logic [3:0] k);
    wait_drained();
    write_size(CFG_ROWS, r);
    write_size(CFG_COLS, c);
    write_size(CFG_INNER, k);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Writes every element that the current sizes read, the last one with go.
  task automatic load_and_run(bit extreme_neg);
    int m, n, kk;
    logic signed [15:0] v;
    m = clip_dim(n_rows);
    n = clip_dim(n_cols);
    kk = clip_dim(n_inner);
    for (int i = 0; i < m; i++) begin
      for (int k = 0; k < kk; k++) begin
        v = extreme_neg ? 16'sh8000 : rand_elem();
        send_element(1'b0, i, k, v, 1'b0);
      end
    end
    for (int k = 0; k < kk; k++) begin
      for (int j = 0; j < n; j++) begin
        v = extreme_neg ? 16'sh8000 : rand_elem();
        send_element(1'b1, k, j, v, (k == kk - 1) && (j == n - 1));
      end
    end
  endtask

  task automatic test_extremes();
    set_sizes(4'd8, 4'd8, 4'd8);
    load_and_run(1'b1);
    set_sizes(4'd1, 4'd1, 4'd1);
    send_element(1'b0, 0, 0, 16'sh7FFF, 1'b0);
    send_element(1'b1, 0, 0, 16'sh8000, 1'b1);
    send_element(1'b1, 0, 0, 16'sh7FFF, 1'b1);
    send_element(1'b0, 7, 7, 16'sh0001, 1'b0);
    send_element(1'b1, 7, 7, 16'shFFFF, 1'b1);
  endtask

  task automatic test_clamped_sizes();
    set_sizes(4'd0, 4'd15, 4'd0);
    send_element(1'b0, 0, 0, 16'sh0100, 1'b1);
    set_sizes(4'd15, 4'd0, 4'd9);
    send_element(1'b1, 7, 0, 16'sh5A5A, 1'b1);
  endtask

  task automatic test_random_products();
    while (n_items < 400) begin
      bursty = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: set_sizes(4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)),
                     4'($urandom_range(1, 3)));
        1: set_sizes(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                     4'($urandom_range(1, 8)));
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        for (int t = $urandom_range(1, 4); t > 0; t--) begin
          send_element($urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 7),
                       rand_elem(), 1'b0);
        end
        send_element(1'b0, 0, 0, rand_elem(), 1'b1);
      end else begin
        load_and_run(1'b0);
      end
    end
    bursty = 1'b1;
  endtask

  task automatic test_backpressure();
    set_sizes(4'd4, 4'd8, 4'd2);
    load_and_run(1'b0);
    hold_off = 1'b1;
    send_element(1'b0, 1, 1, rand_elem(), 1'b1);
    wait_drained();
    send_element(1'b1, 1, 7, rand_elem(), 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 9) < 3) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 30);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    c_elem_t exp_c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_c.size() == 0) begin
        $error("result row %0d col %0d with nothing expected", out_ch.out_row, out_ch.out_col);
        n_errors++;
      end else begin
        exp_c = pending_c.pop_front();
        if (out_ch.out_row !== exp_c.row) begin
          $error("out_row: expected %0d, got %0d", exp_c.row, out_ch.out_row);
          n_errors++;
        end
        if (out_ch.out_col !== exp_c.col) begin
          $error("out_col: expected %0d, got %0d", exp_c.col, out_ch.out_col);
          n_errors++;
        end
        if (out_ch.product_value !== exp_c.value) begin
          $error("product_value: expected %0d, got %0d", exp_c.value, out_ch.product_value);
          n_errors++;
        end
        if (out_ch.last !== exp_c.last) begin
          $error("last: expected %0d, got %0d", exp_c.last, out_ch.last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_clamped_sizes();
    test_backpressure();
    test_random_products();
    wait_drained();
    if (pending_c.size() != 0) n_errors++;
    $display("Sent %0d items, %0d products started, %0d result elements checked.",
             n_items, n_runs, n_results);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
